// File: src/spmf_pkg.sv
`timescale 1ns / 1ps

package spmf_pkg;

	localparam int LEVELS      = 8;
	localparam int LEVEL_DEPTH = 16;
	localparam int DATA_WIDTH  = 32;

	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PTR_W     = $clog2(LEVEL_DEPTH);
	localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
	localparam int ADDR_W    = LVL_W + PTR_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int TOTAL_W   = 8;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} cmd_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		if (ptr == PTR_W'(LEVEL_DEPTH - 1)) begin
			return '0;
		end
		return ptr + PTR_W'(1);
	endfunction

endpackage

// File: src/spmf_ctrl.sv
`timescale 1ns / 1ps

module spmf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output spmf_pkg::cmd_t cmd
);
	import spmf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   can_load;
	logic   accept;

	// the output register is free when empty or drained in this cycle
	assign can_load = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) || ((state_q == ST_DONE) && can_load));
	assign accept   = in_valid && !in_stall;

	assign cmd.capture  = accept;
	assign cmd.exec     = (state_q == ST_EXEC);
	assign cmd.load_out = (state_q == ST_DONE) && can_load;

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (can_load) begin
					state_d = accept ? ST_EXEC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted item did not start execution");

	a_exec_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_DONE)
		else $error("execution did not reach result stage");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

// File: src/spmf_dp.sv
`timescale 1ns / 1ps

module spmf_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  spmf_pkg::cmd_t cmd,
	input  logic           op,
	input  logic [2:0]     level,
	input  logic [31:0]    value,
	output logic [1:0]     status,
	output logic [31:0]    popped_value,
	output logic [2:0]     popped_level,
	output logic [7:0]     total_count
);
	import spmf_pkg::*;

	logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;

	logic [PTR_W-1:0]   head_q [LEVELS];
	logic [PTR_W-1:0]   tail_q [LEVELS];
	logic [CNT_W-1:0]   cnt_q  [LEVELS];
	logic [TOTAL_W-1:0] total_q;

	logic                  op_q;
	logic [2:0]            lvl_q;
	logic [DATA_WIDTH-1:0] val_q;

	status_t          res_status_q;
	logic [LVL_W-1:0] res_lvl_q;
	logic             res_pop_ok_q;

	logic [1:0]  out_status_q;
	logic [31:0] out_value_q;
	logic [2:0]  out_level_q;
	logic [7:0]  out_total_q;

	logic [LVL_W-1:0]  lvl_idx;
	logic              in_range;
	logic              push_ok;
	logic              pop_found;
	logic [LVL_W-1:0]  sel_lvl;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;

	assign lvl_idx  = LVL_W'(lvl_q);
	assign in_range = 32'(lvl_q) < 32'(LEVELS);
	assign push_ok  = in_range && (cnt_q[lvl_idx] != CNT_W'(LEVEL_DEPTH));

	// priority encoder over the per-level counts, level 0 wins
	always_comb begin
		pop_found = 1'b0;
		sel_lvl   = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (cnt_q[l] != '0) begin
				pop_found = 1'b1;
				sel_lvl   = LVL_W'(l);
			end
		end
	end

	assign mem_we   = cmd.exec && !op_q && push_ok;
	assign mem_re   = cmd.exec && op_q && pop_found;
	assign mem_addr = op_q ? {sel_lvl, head_q[sel_lvl]} : {lvl_idx, tail_q[lvl_idx]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= val_q;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			lvl_q <= level;
			val_q <= DATA_WIDTH'(value);
		end
		if (cmd.exec) begin
			res_lvl_q    <= sel_lvl;
			res_pop_ok_q <= op_q && pop_found;
			if (!op_q) begin
				res_status_q <= push_ok ? STATUS_OK : STATUS_FULL;
			end else begin
				res_status_q <= pop_found ? STATUS_OK : STATUS_EMPTY;
			end
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_pop_ok_q ? 32'(rd_q) : '0;
			out_level_q  <= res_pop_ok_q ? 3'(res_lvl_q) : '0;
			out_total_q  <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
			total_q <= '0;
		end else if (cmd.exec) begin
			if (!op_q) begin
				if (push_ok) begin
					tail_q[lvl_idx] <= next_ptr(tail_q[lvl_idx]);
					cnt_q[lvl_idx]  <= cnt_q[lvl_idx] + CNT_W'(1);
					total_q         <= total_q + TOTAL_W'(1);
				end
			end else if (pop_found) begin
				head_q[sel_lvl] <= next_ptr(head_q[sel_lvl]);
				cnt_q[sel_lvl]  <= cnt_q[sel_lvl] - CNT_W'(1);
				total_q         <= total_q - TOTAL_W'(1);
			end
		end
	end

	assign status       = out_status_q;
	assign popped_value = out_value_q;
	assign popped_level = out_level_q;
	assign total_count  = out_total_q;

`ifndef SYNTHESIS
	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> total_q == $past(total_q) + TOTAL_W'(1))
		else $error("accepted push did not raise the total");

	a_pop_level_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> cnt_q[$past(sel_lvl)] == $past(cnt_q[sel_lvl]) - CNT_W'(1))
		else $error("pop did not lower the served level count");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && op_q && !pop_found |-> total_q == '0)
		else $error("all levels empty but total nonzero");
`endif

endmodule

// File: src/strict_priority_multi_fifo_top.sv
`timescale 1ns / 1ps
// an item is captured into the input registers, executed in the exec state, and its
//   result is loaded into the output register in the done state once it is free
// a new item is taken only after the registered store read and pointer/count update
//   of the last one, while the previous result waits in the output register
// reset: asynchronous, clears pointers, level counts, total and handshake state;
//   entry store is not cleared

module strict_priority_multi_fifo_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [2:0]  level,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] popped_value,
	output logic [2:0]  popped_level,
	output logic [7:0]  total_count
);
	import spmf_pkg::*;

	cmd_t cmd;

	spmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	spmf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (op),
		.level        (level),
		.value        (value),
		.status       (status),
		.popped_value (popped_value),
		.popped_level (popped_level),
		.total_count  (total_count)
	);

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	import spmf_pkg::*;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam int RANDOM_ITEMS = 2000;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 29;
	// no idling on either side while this many transfers have gone through
	localparam int STEADY_FROM  = 800;
	localparam int STEADY_TO    = 1200;

	typedef struct {
		logic        op;
		logic [2:0]  level;
		logic [31:0] value;
	} queue_cmd_t;

	typedef struct {
		status_t     status;
		logic [31:0] popped_value;
		logic [2:0]  popped_level;
		logic [7:0]  total_count;
	} queue_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = OP_PUSH;
	logic [2:0]  level = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] popped_value;
	logic [2:0]  popped_level;
	logic [7:0]  total_count;

	queue_cmd_t   cmd_backlog[$];
	queue_reply_t expected_replies[$];

	// shadow copy of the per-level rings
	logic [DATA_WIDTH-1:0] shadow_store[LEVELS][LEVEL_DEPTH];
	int                    shadow_head[LEVELS];
	int                    shadow_count[LEVELS];
	int                    shadow_total = 0;

	int cmds_sent = 0;
	int replies_seen = 0;
	int failures = 0;
	int cycle_count = 0;

	queue_cmd_t   next_cmd;
	queue_reply_t seen_reply;

	strict_priority_multi_fifo_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.level        (level),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.popped_value (popped_value),
		.popped_level (popped_level),
		.total_count  (total_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic queue_reply_t serve_cmd(input queue_cmd_t c);
		queue_reply_t r;
		int           lvl;
		int           hit;
		r.status       = STATUS_OK;
		r.popped_value = '0;
		r.popped_level = '0;
		hit            = -1;
		if (c.op == OP_PUSH) begin
			lvl = int'(c.level);
			if (lvl >= LEVELS || shadow_count[lvl] >= LEVEL_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				shadow_store[lvl][(shadow_head[lvl] + shadow_count[lvl]) % LEVEL_DEPTH] =
					c.value[DATA_WIDTH-1:0];
				shadow_count[lvl]++;
				shadow_total++;
			end
		end else begin
			// lowest-numbered non-empty level wins
			for (int l = LEVELS - 1; l >= 0; l--) begin
				if (shadow_count[l] != 0) begin
					hit = l;
				end
			end
			if (hit < 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.popped_value = 32'(shadow_store[hit][shadow_head[hit]]);
				r.popped_level = 3'(hit);
				shadow_head[hit] = (shadow_head[hit] + 1) % LEVEL_DEPTH;
				shadow_count[hit]--;
				shadow_total--;
			end
		end
		r.total_count = 8'(shadow_total);
		return r;
	endfunction

	task automatic queue_cmd(input logic o, input logic [2:0] l, input logic [31:0] v);
		queue_cmd_t c;
		c.op    = o;
		c.level = l;
		c.value = v;
		cmd_backlog.push_back(c);
	endtask

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			return '0;
		end
		if (r == 1) begin
			return '1;
		end
		return $urandom;
	endfunction

	// stimulus driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op       <= OP_PUSH;
			level    <= '0;
			value    <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				next_cmd.op    = op;
				next_cmd.level = level;
				next_cmd.value = value;
				expected_replies.push_back(serve_cmd(next_cmd));
				cmds_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (cmd_backlog.size() != 0 &&
				    !((cmds_sent < STEADY_FROM || cmds_sent >= STEADY_TO) &&
				      $urandom_range(99) < IDLE_PCT)) begin
					next_cmd = cmd_backlog.pop_front();
					in_valid <= 1'b1;
					op       <= next_cmd.op;
					level    <= next_cmd.level;
					value    <= next_cmd.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				replies_seen++;
				if (expected_replies.size() == 0) begin
					$error("result transfer with no prediction pending");
					failures++;
				end else begin
					seen_reply = expected_replies.pop_front();
					if (status !== seen_reply.status) begin
						$error("status: expected %0d, actual %0d", seen_reply.status, status);
						failures++;
					end
					if (popped_value !== seen_reply.popped_value) begin
						$error("popped_value: expected %0h, actual %0h",
							seen_reply.popped_value, popped_value);
						failures++;
					end
					if (popped_level !== seen_reply.popped_level) begin
						$error("popped_level: expected %0d, actual %0d",
							seen_reply.popped_level, popped_level);
						failures++;
					end
					if (total_count !== seen_reply.total_count) begin
						$error("total_count: expected %0d, actual %0d",
							seen_reply.total_count, total_count);
						failures++;
					end
				end
			end
			out_stall <= (replies_seen < STEADY_FROM || replies_seen >= STEADY_TO) &&
				($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("strict_priority_multi_fifo_top test failed");
			$finish;
		end
	end

	initial begin
		int made;
		int mode;
		int run_len;
		int focus;
		int push_pct;
		logic [2:0] lvl;

		for (int l = 0; l < LEVELS; l++) begin
			shadow_head[l]  = 0;
			shadow_count[l] = 0;
		end

		// pop while empty, extremes of value and level, priority order on drain
		queue_cmd(OP_POP, 3'd7, '1);
		queue_cmd(OP_PUSH, 3'd7, 32'hFFFF_FFFF);
		queue_cmd(OP_PUSH, 3'd0, 32'h0000_0000);
		queue_cmd(OP_PUSH, 3'd3, 32'hA5A5_5A5A);
		queue_cmd(OP_POP, 3'd0, '0);
		queue_cmd(OP_POP, 3'd5, 32'h1234_5678);
		queue_cmd(OP_POP, 3'd2, '1);
		queue_cmd(OP_POP, 3'd1, '0);
		// fill one level, then one push too many
		for (int i = 0; i <= LEVEL_DEPTH; i++) begin
			queue_cmd(OP_PUSH, 3'd2, $urandom);
		end

		made = 0;
		while (made < RANDOM_ITEMS) begin
			mode    = $urandom_range(4);
			run_len = $urandom_range(10, 60);
			focus   = $urandom_range(LEVELS - 1);
			case (mode)
				0: push_pct = 80;
				1: push_pct = 20;
				2: push_pct = 50;
				3: begin
					push_pct = 100;
					run_len  = $urandom_range(40, 150);
				end
				default: push_pct = 0;
			endcase
			for (int i = 0; i < run_len && made < RANDOM_ITEMS; i++) begin
				// mostly one level per run so levels fill up and wrap
				if (mode != 3 && $urandom_range(99) < 60) begin
					lvl = 3'(focus);
				end else begin
					lvl = 3'($urandom_range(7));
				end
				if ($urandom_range(99) < push_pct) begin
					queue_cmd(OP_PUSH, lvl, pick_value());
				end else begin
					queue_cmd(OP_POP, lvl, pick_value());
				end
				made++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || in_valid || expected_replies.size() != 0) begin
			@(negedge clk);
		end
		repeat (10) @(posedge clk);

		if (failures == 0 && expected_replies.size() == 0) begin
			$display("strict_priority_multi_fifo_top test passed");
		end else begin
			$display("strict_priority_multi_fifo_top test failed");
		end
		$finish;
	end

endmodule

// File: strict_priority_multi_fifo_top.f
src/spmf_pkg.sv
src/spmf_ctrl.sv
src/spmf_dp.sv
src/strict_priority_multi_fifo_top.sv
tb/tb.sv
